[sv/dvd_pkg.sv]
// ---------------------------------------------------------------------------
// dvd_pkg: shared types and constants
// Store sizing, controller states and the command/status bundles.
// ---------------------------------------------------------------------------
`default_nettype none
package dvd_pkg;
  localparam int MAX_ITEMS = 4096;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT
  } dvd_state_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic finish;
  } dvd_cmd_t;

  typedef struct packed {
    logic scan_more;
    logic rd_vld;
    logic is_last;
    logic out_busy;
  } dvd_stat_t;
endpackage
`default_nettype wire

[sv/dvd_ctrl.sv]
// ---------------------------------------------------------------------------
// dvd_ctrl: controller
// Accepts one value, runs its scan against earlier values, closes the set.
// ---------------------------------------------------------------------------
`default_nettype none
module dvd_ctrl import dvd_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire dvd_stat_t stat,
  output dvd_cmd_t       cmd
);
  dvd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  wire logic scan_done = !stat.scan_more && !stat.rd_vld;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (scan_done) begin
          if (stat.is_last && stat.out_busy) state_nxt = ST_WAIT;
          else                               state_nxt = ST_IDLE;
        end
      end
      ST_WAIT: if (!stat.out_busy) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.issue  = stat.scan_more;
        cmd.finish = scan_done && stat.is_last && !stat.out_busy;
      end
      ST_WAIT: cmd.finish = !stat.out_busy;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

[sv/dvd_dp.sv]
// ---------------------------------------------------------------------------
// dvd_dp: datapath
// Value store, scan pointer, compare, set flags and the result register.
// ---------------------------------------------------------------------------
`default_nettype none
module dvd_dp import dvd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [31:0] in_value,
  input  wire logic        in_last,
  input  wire dvd_cmd_t    cmd,
  output dvd_stat_t        stat,
  input  wire logic        out_ready,
  output logic             out_valid,
  output logic             out_dup,
  output logic             out_ovf
);
  logic [31:0]       mem [MAX_ITEMS];
  logic [31:0]       rd_data_r;
  logic [31:0]       value_r;
  logic              last_r;
  logic [ADDR_W-1:0] idx_r, end_r;
  logic [CNT_W-1:0]  count_r;
  logic              ovf_r, dup_r, rd_vld_r, out_valid_r, out_dup_r, out_ovf_r;

  wire logic full = (count_r == CNT_W'(MAX_ITEMS));

  always_ff @(posedge clk) begin
    if (cmd.load && !full) mem[count_r[ADDR_W-1:0]] <= in_value;
    if (cmd.issue) rd_data_r <= mem[idx_r];
    if (cmd.load) begin
      value_r <= in_value;
      last_r  <= in_last;
    end
    if (cmd.finish) begin
      out_dup_r <= dup_r;
      out_ovf_r <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      dup_r       <= 1'b0;
      rd_vld_r    <= 1'b0;
      idx_r       <= '0;
      end_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.issue;
      if (cmd.load) begin
        idx_r <= '0;
        // a full store means no compare for this value
        end_r <= full ? '0 : count_r[ADDR_W-1:0];
        if (full) ovf_r   <= 1'b1;
        else      count_r <= count_r + CNT_W'(1);
      end
      if (cmd.issue) idx_r <= idx_r + ADDR_W'(1);
      if (rd_vld_r && rd_data_r == value_r) dup_r <= 1'b1;
      if (cmd.finish) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
        dup_r   <= 1'b0;
      end
      if (cmd.finish)                  out_valid_r <= 1'b1;
      else if (out_ready)              out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    stat.scan_more = (idx_r != end_r) && !dup_r;
    stat.rd_vld    = rd_vld_r;
    stat.is_last   = last_r;
    stat.out_busy  = out_valid_r && !out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_dup   = out_dup_r;
  assign out_ovf   = out_ovf_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ITEMS)) else $error("store count beyond capacity");
  a_rd_from_issue: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> $past(cmd.issue)) else $error("read data without read");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !(out_valid_r && !out_ready)) else $error("result overwritten");
  a_no_load_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> !cmd.load) else $error("load during scan");
`endif
endmodule
`default_nettype wire

[sv/duplicate_value_detector_unit.sv]
// ---------------------------------------------------------------------------
// duplicate_value_detector_unit: duplicate detector top level
// Checks whether a set of 32-bit values holds two equal values.
// ---------------------------------------------------------------------------
// usage:
//   in channel carries one value per transaction; in_tlast marks the last
//   value of a set. the last transaction yields one result on the out
//   channel: out_tdata[0] duplicate found, out_tdata[1] set overflowed.
//   each accepted value is written to a 4096-entry store and then compared
//   against the earlier values of the set through the single read port,
//   one entry per cycle, until a duplicate is seen. no new value is taken
//   until that scan is over: the block issues the reads, drains the last
//   read, ends the scan and returns to idle. no scan is run when no value
//   is stored yet, once a duplicate has been seen or once the store is full.
//   values beyond 4096 only raise the overflow flag.
//   out_tvalid rises once the scan of the last value is done. the result
//   sits in an output register, so a new set is taken while it waits; if a
//   second result is due before the first is taken the block holds off
//   input until out_tready. reset clears the set and the result valid flag;
//   store contents need no clearing.
// ---------------------------------------------------------------------------
`default_nettype none
module duplicate_value_detector_unit import dvd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // item_value
  input  wire logic        in_tlast,   // last_item
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata   // duplicate_found, set_overflowed, zeros
);
  dvd_cmd_t  cmd;
  dvd_stat_t stat;
  logic      dup, ovf;

  dvd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dvd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_value  (in_tdata),
    .in_last   (in_tlast),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_dup   (dup),
    .out_ovf   (ovf)
  );

  assign out_tdata = {6'b0, ovf, dup};
endmodule
`default_nettype wire
